// File: hw/rtl/kwm_pkg.sv
// Shared types and constants for the k-way sorted merge block.
// Holds command and status codes, the sequencer state type and default sizes.
// No dependencies.
package kwm_pkg;

    // default sizes
    localparam int KWM_LISTS       = 16;
    localparam int KWM_LIST_DEPTH  = 64;
    localparam int KWM_VALUE_WIDTH = 32;

    // fixed field widths
    localparam int KWM_CMD_W    = 2;
    localparam int KWM_IDX_W    = 4;
    localparam int KWM_STATUS_W = 2;
    localparam int KWM_CFG_W    = 5;

    // lists in use after reset
    localparam logic [KWM_CFG_W-1:0] KWM_CFG_RESET = 5'd16;

    typedef enum logic [KWM_CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [KWM_STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // sequencer: idle, head refill from the store, wait for the min tree
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LOAD   = 2'd1,
        S_SETTLE = 2'd2
    } t_state;

endpackage

// File: hw/rtl/kwm_cmd_if.sv
// Command channel: valid/ready handshake carrying cmd, list_index and value.
// Depends on kwm_pkg.
interface kwm_cmd_if import kwm_pkg::*; #(
    parameter int VALUE_WIDTH = KWM_VALUE_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic [KWM_CMD_W-1:0]          cmd;
    logic [KWM_IDX_W-1:0]          list_index;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, cmd, list_index, value, input ready);
    modport sink   (input valid, cmd, list_index, value, output ready);
endinterface

// File: hw/rtl/kwm_rsp_if.sv
// Response channel: valid/ready handshake carrying status, out_value, out_list.
// Depends on kwm_pkg.
interface kwm_rsp_if import kwm_pkg::*; #(
    parameter int VALUE_WIDTH = KWM_VALUE_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic [KWM_STATUS_W-1:0]       status;
    logic signed [VALUE_WIDTH-1:0] out_value;
    logic [KWM_IDX_W-1:0]          out_list;

    modport source (output valid, status, out_value, out_list, input ready);
    modport sink   (input valid, status, out_value, out_list, output ready);
endinterface

// File: hw/rtl/kwm_list_store.sv
// Element store for all lists: one write port, one read port, registered read.
// Address is {list, slot}. Depends on kwm_pkg.
module kwm_list_store import kwm_pkg::*; #(
    parameter int LISTS       = KWM_LISTS,
    parameter int LIST_DEPTH  = KWM_LIST_DEPTH,
    parameter int VALUE_WIDTH = KWM_VALUE_WIDTH,
    localparam int IW         = $clog2(LISTS),
    localparam int PW         = $clog2(LIST_DEPTH),
    localparam int AW         = IW + PW
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic signed [VALUE_WIDTH-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic signed [VALUE_WIDTH-1:0] o_rd_data
);
    localparam int MEM_DEPTH = LISTS * (1 << PW);

    logic signed [VALUE_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: hw/rtl/kwm_min_tree.sv
// Registered comparison tree over the list heads: finds the least valid head,
// ties going to the higher list index. One register level per tree level.
// Depends on kwm_pkg.
module kwm_min_tree import kwm_pkg::*; #(
    parameter int LISTS       = KWM_LISTS,
    parameter int VALUE_WIDTH = KWM_VALUE_WIDTH,
    localparam int IW         = $clog2(LISTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [LISTS-1:0]              i_leaf_vld,
    input  logic signed [VALUE_WIDTH-1:0] i_leaf_key [LISTS],
    output logic                          o_vld,
    output logic [IW-1:0]                 o_idx,
    output logic signed [VALUE_WIDTH-1:0] o_key
);
    localparam int LEAVES = 1 << IW;

    // heap numbering: node n has children 2n and 2n+1, leaves at LEAVES..
    logic                          w_vld [1:2*LEAVES-1];
    logic signed [VALUE_WIDTH-1:0] w_key [1:2*LEAVES-1];
    logic [IW-1:0]                 w_idx [1:2*LEAVES-1];

    logic                          r_vld [1:LEAVES-1];
    logic signed [VALUE_WIDTH-1:0] r_key [1:LEAVES-1];
    logic [IW-1:0]                 r_idx [1:LEAVES-1];

    // leaves come straight from the head registers; padding leaves are empty
    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < LISTS) begin : g_real
            assign w_vld[LEAVES+j] = i_leaf_vld[j];
            assign w_key[LEAVES+j] = i_leaf_key[j];
        end else begin : g_pad
            assign w_vld[LEAVES+j] = 1'b0;
            assign w_key[LEAVES+j] = '0;
        end
        assign w_idx[LEAVES+j] = IW'(j);
    end

    // inner nodes: right child holds the higher indexes, so it wins ties
    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        assign w_vld[n] = r_vld[n];
        assign w_key[n] = r_key[n];
        assign w_idx[n] = r_idx[n];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[n] <= 1'b0;
            end else begin
                r_vld[n] <= w_vld[2*n] | w_vld[2*n+1];
            end
            if (w_vld[2*n+1] && (!w_vld[2*n] || w_key[2*n+1] <= w_key[2*n])) begin
                r_key[n] <= w_key[2*n+1];
                r_idx[n] <= w_idx[2*n+1];
            end else begin
                r_key[n] <= w_key[2*n];
                r_idx[n] <= w_idx[2*n];
            end
        end
    end

    assign o_vld = r_vld[1];
    assign o_idx = r_idx[1];
    assign o_key = r_key[1];
endmodule

// File: hw/rtl/k_way_sorted_merge.sv
// k-way merge of sorted lists. Result is registered and valid the cycle after accept.
// After each command the block waits in S_SETTLE for the registered min tree over the
// heads to settle before it takes the next; a pop that leaves its list nonempty first
// refills the head from the store in S_LOAD.
// Synchronous active-low reset empties all lists and sets lists_in_use to 16;
// store contents are not cleared. Depends on kwm_pkg, the interfaces and submodules.
module k_way_sorted_merge import kwm_pkg::*; #(
    parameter int LISTS       = KWM_LISTS,
    parameter int LIST_DEPTH  = KWM_LIST_DEPTH,
    parameter int VALUE_WIDTH = KWM_VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kwm_cmd_if.sink              i_cmd,
    kwm_rsp_if.source            o_rsp,
    input  logic                 i_cfg_wr_en,
    input  logic [KWM_CFG_W-1:0] i_cfg_wr_data
);
    localparam int IW     = $clog2(LISTS);
    localparam int PW     = $clog2(LIST_DEPTH);
    localparam int FW     = $clog2(LIST_DEPTH + 1);
    localparam int LEVELS = IW;
    localparam int CW     = $clog2(LEVELS + 1);

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        f_next = (p == PW'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // per-list bookkeeping and cached heads
    logic [FW-1:0]                 r_fill [LISTS];
    logic [PW-1:0]                 r_rd   [LISTS];
    logic [PW-1:0]                 r_wr   [LISTS];
    logic signed [VALUE_WIDTH-1:0] r_head [LISTS];

    logic [KWM_CFG_W-1:0] r_cfg;
    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [IW-1:0]        r_win;

    logic                          r_out_vld;
    t_status                       r_out_status;
    logic signed [VALUE_WIDTH-1:0] r_out_value;
    logic [KWM_IDX_W-1:0]          r_out_list;

    logic                          w_in_acc;
    logic [LISTS-1:0]              w_leaf_vld;
    logic                          w_tree_vld;
    logic [IW-1:0]                 w_win;
    logic signed [VALUE_WIDTH-1:0] w_tree_key;
    logic signed [VALUE_WIDTH-1:0] w_rd_data;
    logic [IW-1:0]                 w_pidx;
    logic                          w_idx_ok;
    logic                          w_push_full;
    logic                          w_do_push, w_do_pop, w_do_clear, w_refill;
    t_status                       n_status;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic [KWM_IDX_W-1:0]          n_list;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= KWM_CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    // a list takes part when its index is below lists_in_use and it holds data
    for (genvar i = 0; i < LISTS; i++) begin : g_leaf_vld
        assign w_leaf_vld[i] = (32'(r_cfg) > i) && (r_fill[i] != '0);
    end

    kwm_min_tree #(
        .LISTS       (LISTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_min_tree (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_leaf_vld (w_leaf_vld),
        .i_leaf_key (r_head),
        .o_vld      (w_tree_vld),
        .o_idx      (w_win),
        .o_key      (w_tree_key)
    );

    // handshake: take a command only when idle and the result slot frees up
    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_vld || o_rsp.ready);
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;

    // push target checks
    assign w_pidx      = IW'(i_cmd.list_index);
    assign w_idx_ok    = ({1'b0, i_cmd.list_index} < r_cfg)
                         && (32'(i_cmd.list_index) < LISTS);
    assign w_push_full = (r_fill[w_pidx] == FW'(LIST_DEPTH));

    // command decode and result
    always_comb begin
        w_do_push  = 1'b0;
        w_do_pop   = 1'b0;
        w_do_clear = 1'b0;
        w_refill   = 1'b0;
        n_status   = ST_OK;
        n_value    = '0;
        n_list     = '0;
        if (w_in_acc) begin
            case (t_cmd'(i_cmd.cmd))
                CMD_PUSH: begin
                    if (!w_idx_ok) begin
                        n_status = ST_BAD_INDEX;
                    end else if (w_push_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_do_push = 1'b1;
                    end
                end
                CMD_POP: begin
                    if (!w_tree_vld) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_do_pop = 1'b1;
                        w_refill = r_fill[w_win] > FW'(1);
                        n_value  = w_tree_key;
                        n_list   = KWM_IDX_W'(w_win);
                    end
                end
                CMD_CLEAR: begin
                    w_do_clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    kwm_list_store #(
        .LISTS       (LISTS),
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_list_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_do_push),
        .i_wr_addr ({w_pidx, r_wr[w_pidx]}),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (w_refill),
        .i_rd_addr ({w_win, f_next(r_rd[w_win])}),
        .o_rd_data (w_rd_data)
    );

    // per-list pointers, fill counts and heads
    for (genvar i = 0; i < LISTS; i++) begin : g_list
        always_ff @(posedge i_clk) begin
            if (!i_rst_n || w_do_clear) begin
                r_fill[i] <= '0;
                r_rd[i]   <= '0;
                r_wr[i]   <= '0;
            end else begin
                if (w_do_push && w_pidx == IW'(i)) begin
                    r_wr[i]   <= f_next(r_wr[i]);
                    r_fill[i] <= r_fill[i] + 1'b1;
                end
                if (w_do_pop && w_win == IW'(i)) begin
                    r_rd[i]   <= f_next(r_rd[i]);
                    r_fill[i] <= r_fill[i] - 1'b1;
                end
            end
        end

        // head: written through on a push to an empty list, refilled after a pop
        always_ff @(posedge i_clk) begin
            if (w_do_push && w_pidx == IW'(i) && r_fill[i] == '0) begin
                r_head[i] <= i_cmd.value;
            end else if (r_state == S_LOAD && r_win == IW'(i)) begin
                r_head[i] <= w_rd_data;
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_refill ? S_LOAD : S_SETTLE;
                    n_cnt   = CW'(LEVELS);
                end else if (i_cfg_wr_en) begin
                    n_state = S_SETTLE;
                    n_cnt   = CW'(LEVELS);
                end
            end
            S_LOAD: begin
                n_state = S_SETTLE;
                n_cnt   = CW'(LEVELS);
            end
            S_SETTLE: begin
                if (r_cnt == CW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // winner kept for the head refill
    always_ff @(posedge i_clk) begin
        if (w_do_pop) begin
            r_win <= w_win;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_in_acc) begin
            r_out_status <= n_status;
            r_out_value  <= n_value;
            r_out_list   <= n_list;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.out_value = r_out_value;
    assign o_rsp.out_list  = r_out_list;
endmodule
